// ===== rtl/rewa_pkg.sv =====
`timescale 1ns / 1ps

package rewa_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int AGE_W          = 16;
    localparam int WLEN_W         = 11;
    localparam int CFG_IDX_W      = 1;
    localparam int MAX_WINDOW_DEF = 1024;

    localparam logic [AGE_W-1:0]  AGE_LIMIT  = 16'hFFFF;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 11'd20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FIND_MINIMUM  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic update;
        logic scan;
        logic emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/rewa_ram.sv =====
`timescale 1ns / 1ps

module rewa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/rewa_ctrl.sv =====
`timescale 1ns / 1ps

module rewa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rewa_pkg::dp_stat_t stat,
    output rewa_pkg::dp_cmd_t  cmd
);

    import rewa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = stat.need_scan ? ST_SCAN : ST_RESULT;
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_RESULT:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/rewa_dp.sv =====
`timescale 1ns / 1ps

module rewa_dp #(
    parameter int MAX_WINDOW = rewa_pkg::MAX_WINDOW_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rewa_pkg::dp_cmd_t                      cmd,
    output rewa_pkg::dp_stat_t                     stat,
    input  logic signed [rewa_pkg::SAMPLE_W-1:0]   sample,
    input  logic                                   series_start,
    input  logic                                   cfg_we,
    input  logic [rewa_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rewa_pkg::WLEN_W-1:0]            cfg_data,
    input  logic                                   out_ready,
    output logic                                   out_valid,
    output logic signed [rewa_pkg::SAMPLE_W-1:0]   extreme_value,
    output logic [rewa_pkg::AGE_W-1:0]             bars_since
);

    import rewa_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int SW = AW + 2;

    localparam logic [AW-1:0] SLOT_LAST = AW'(MAX_WINDOW - 1);
    localparam logic [CW-1:0] FILL_FULL = CW'(MAX_WINDOW);
    localparam logic [SW-1:0] DEPTH_SW  = SW'(MAX_WINDOW);

    function automatic logic beats(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input logic                       fmin
    );
        return fmin ? (a <= b) : (a >= b);
    endfunction

    // configuration
    logic [WLEN_W-1:0] wlen_reg;
    logic              fmin_reg;

    // captured request
    logic signed [SAMPLE_W-1:0] smp_reg;
    logic                       start_reg;

    // history state
    logic [AW-1:0]              slot_reg,  slot_next;
    logic [CW-1:0]              fill_reg,  fill_next;
    logic signed [SAMPLE_W-1:0] held_reg,  held_next;
    logic [AGE_W-1:0]           age_reg,   age_next;

    // rescan state
    logic [AW-1:0]              rd_addr_reg,    rd_addr_next;
    logic [CW-1:0]              issue_left_reg, issue_left_next;
    logic                       pipe_valid_reg, pipe_valid_next;
    logic [CW-1:0]              pipe_k_reg,     pipe_k_next;
    logic                       have_reg,       have_next;

    // output register
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_value_reg;
    logic [AGE_W-1:0]           out_bars_reg;

    // update terms
    logic [AW-1:0]     slot_base, slot_inc;
    logic [CW-1:0]     fill_base, fill_inc;
    logic              first;
    logic [AGE_W-1:0]  age_inc;
    logic [31:0]       wlen_ext;
    logic [CW-1:0]     n_eff;
    logic              expire;
    logic [CW-1:0]     span;
    logic [SW-1:0]     base_sum, base_addr;
    logic              issue;
    logic [SAMPLE_W-1:0] ram_rdata;

    always_comb
    begin
        slot_base = start_reg ? '0 : slot_reg;
        fill_base = start_reg ? '0 : fill_reg;
        first     = (fill_base == '0);
        slot_inc  = (slot_base == SLOT_LAST) ? '0 : slot_base + 1'b1;
        fill_inc  = (fill_base == FILL_FULL) ? fill_base : fill_base + 1'b1;
        age_inc   = (age_reg == AGE_LIMIT) ? age_reg : age_reg + 1'b1;

        // oversized window acts as the full store
        wlen_ext  = 32'(wlen_reg);
        n_eff     = (wlen_ext > 32'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : CW'(wlen_ext);
        expire    = !first && (n_eff != '0) && (32'(age_inc) >= 32'(n_eff));

        span      = (32'(n_eff) < 32'(fill_inc)) ? n_eff : fill_inc;
        base_sum  = SW'(slot_inc) + DEPTH_SW - SW'(span);
        base_addr = (base_sum >= DEPTH_SW) ? base_sum - DEPTH_SW : base_sum;

        issue     = cmd.scan && (issue_left_reg != '0);
    end

    always_comb
    begin
        slot_next       = slot_reg;
        fill_next       = fill_reg;
        held_next       = held_reg;
        age_next        = age_reg;
        rd_addr_next    = rd_addr_reg;
        issue_left_next = issue_left_reg;
        pipe_valid_next = pipe_valid_reg;
        pipe_k_next     = pipe_k_reg;
        have_next       = have_reg;

        if (cmd.update)
        begin
            slot_next = slot_inc;
            fill_next = fill_inc;
            priority if (first)
            begin
                held_next = smp_reg;
                age_next  = '0;
            end
            else if (expire)
            begin
                // rescan oldest to newest, the new sample included
                age_next        = age_inc;
                rd_addr_next    = AW'(base_addr);
                issue_left_next = span;
                pipe_valid_next = 1'b0;
                have_next       = 1'b0;
            end
            else if (beats(smp_reg, held_reg, fmin_reg))
            begin
                held_next = smp_reg;
                age_next  = '0;
            end
            else
            begin
                age_next = age_inc;
            end
        end

        if (cmd.scan)
        begin
            pipe_valid_next = issue;
            if (issue)
            begin
                rd_addr_next    = (rd_addr_reg == SLOT_LAST) ? '0 : rd_addr_reg + 1'b1;
                issue_left_next = issue_left_reg - 1'b1;
                pipe_k_next     = issue_left_reg - 1'b1;
            end
            // ties go to the newer entry
            if (pipe_valid_reg &&
                (!have_reg || beats($signed(ram_rdata), held_reg, fmin_reg)))
            begin
                held_next = $signed(ram_rdata);
                age_next  = AGE_W'(pipe_k_reg);
                have_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg       <= WLEN_RESET;
            fmin_reg       <= 1'b0;
            slot_reg       <= '0;
            fill_reg       <= '0;
            held_reg       <= '0;
            age_reg        <= '0;
            issue_left_reg <= '0;
            pipe_valid_reg <= 1'b0;
            have_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_WINDOW_LENGTH))
            begin
                wlen_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_FIND_MINIMUM))
            begin
                fmin_reg <= cfg_data[0];
            end
            slot_reg       <= slot_next;
            fill_reg       <= fill_next;
            held_reg       <= held_next;
            age_reg        <= age_next;
            issue_left_reg <= issue_left_next;
            pipe_valid_reg <= pipe_valid_next;
            have_reg       <= have_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            smp_reg   <= sample;
            start_reg <= series_start;
        end
        rd_addr_reg <= rd_addr_next;
        pipe_k_reg  <= pipe_k_next;
        if (cmd.emit)
        begin
            out_value_reg <= held_reg;
            out_bars_reg  <= age_reg;
        end
    end

    rewa_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_window (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (slot_base),
        .wdata (smp_reg),
        .re    (issue),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        stat.need_scan = expire;
        stat.scan_done = (issue_left_reg == '0) && !pipe_valid_reg;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign extreme_value = out_value_reg;
    assign bars_since    = out_bars_reg;

    // a result is never loaded over one that is still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending result");

    // the first sample of a series is its own extremum
    a_first_age: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && first) |=> (age_reg == '0))
        else $error("age not cleared on first sample");

    // read data only comes back while the rescan is running
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_valid_reg |-> cmd.scan)
        else $error("read data outside rescan");

    // fill count saturates at the store depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= 32'(MAX_WINDOW))
        else $error("fill count beyond store depth");

endmodule

// ===== rtl/rolling_extremum_with_age_core.sv =====
`timescale 1ns / 1ps

// Rolling window maximum or minimum with age. Each request carries one signed
// 32-bit sample; each produces one result: the extremum of the last
// window_length samples of the current series (every sample so far while the
// window is still filling, or always when window_length is 0) and bars_since,
// the samples elapsed since the newest occurrence of that extremum, saturating
// at 65535. find_minimum selects minimum instead of maximum. series_start
// clears the history; the first request after reset starts a series as well.
// A window_length above MAX_WINDOW acts as MAX_WINDOW. Samples sit in a
// MAX_WINDOW-deep single-write, single-read memory. An item passes through
// accept, update and result when the held extremum stays in the window;
// when it expires, a rescan between update and result reads the memory back
// one entry per cycle from the oldest sample, span entries in all, span being
// the smaller of window_length and the samples seen in the series (at most
// MAX_WINDOW). in_ready is high only between items; a finished result waits
// in an output register and does not block the next request from entering.
// The user writes configuration through cfg_we / cfg_index / cfg_data only
// while idle (the block does not enforce it); no clearing pass after reset.

module rolling_extremum_with_age_core #(
    parameter int MAX_WINDOW = rewa_pkg::MAX_WINDOW_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // sample requests
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [rewa_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 series_start,

    // results
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [rewa_pkg::SAMPLE_W-1:0] extreme_value,
    output logic [rewa_pkg::AGE_W-1:0]           bars_since,

    // configuration writes
    input  logic                                 cfg_we,
    input  logic [rewa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rewa_pkg::WLEN_W-1:0]          cfg_data
);

    import rewa_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: accept, update, optional rescan, result
    rewa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // history memory, held extremum and age, output register
    rewa_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .sample        (sample),
        .series_start  (series_start),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .extreme_value (extreme_value),
        .bars_since    (bars_since)
    );

endmodule

// ===== tb/sv/rolling_extremum_with_age_core_tb.sv =====
`timescale 1ns / 1ps

module rolling_extremum_with_age_core_tb;

    import rewa_pkg::*;

    localparam int          HIST_DEPTH  = MAX_WINDOW_DEF;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int          RX_HOLD_LEN = 300;   // long receiver hold-off
    localparam int          RX_HOLD_AT  = 60;    // result count that triggers it

    // one sample request as queued for the driver
    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       start;
    } sample_req_t;

    // one predicted result
    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic [AGE_W-1:0]           age;
    } extremum_t;

    // dut ports; the inputs are known from time zero
    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       in_valid     = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample       = '0;
    logic                       series_start = 1'b0;
    logic                       out_valid;
    logic                       out_ready    = 1'b0;
    logic signed [SAMPLE_W-1:0] extreme_value;
    logic [AGE_W-1:0]           bars_since;
    logic                       cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index    = '0;
    logic [WLEN_W-1:0]          cfg_data     = '0;

    // stimulus and scoreboard
    sample_req_t pending_samples[$];
    extremum_t   expected_extrema[$];
    extremum_t   oldest_extremum;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned n_results     = 0;
    int unsigned n_errors      = 0;
    int unsigned cycle_count   = 0;
    int          rx_hold_left  = 0;
    bit          rx_hold_done  = 1'b0;
    int          price_walk    = 1000;

    // shadow of the block: sample history, fill, held extremum and its age
    logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
    int unsigned                hist_slot  = 0;
    int unsigned                hist_fill  = 0;
    logic signed [SAMPLE_W-1:0] held_value = '0;
    int unsigned                held_bars  = 0;
    logic [WLEN_W-1:0]          win_len    = WLEN_RESET;
    logic                       track_min  = 1'b0;

    rolling_extremum_with_age_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .series_start  (series_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .extreme_value (extreme_value),
        .bars_since    (bars_since),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // ties always hand the extremum to the newer sample
    function automatic bit displaces(logic signed [SAMPLE_W-1:0] a,
                                     logic signed [SAMPLE_W-1:0] b);
        return track_min ? (a <= b) : (a >= b);
    endfunction

    // advance the shadow by one accepted request and queue the result it must give
    task automatic predict_extremum(input logic signed [SAMPLE_W-1:0] x, input logic start);
        int unsigned span;
        int unsigned k;
        int unsigned idx;
        bit          first;
        bit          have;
        extremum_t   res;
        // oversized windows act as the full history depth
        span = (win_len > HIST_DEPTH) ? HIST_DEPTH : win_len;
        if (start)
        begin
            hist_fill = 0;
            hist_slot = 0;
        end
        // empty history also covers the very first request after reset
        first = (hist_fill == 0);
        hist_mem[hist_slot] = x;
        hist_slot = (hist_slot + 1) % HIST_DEPTH;
        if (hist_fill < HIST_DEPTH)
            hist_fill++;
        if (first)
        begin
            held_value = x;
            held_bars  = 0;
        end
        else
        begin
            if (held_bars < AGE_LIMIT)
                held_bars++;
            if (span != 0 && held_bars >= span)
            begin
                // held value left the window: rescan oldest to newest
                k    = (span < hist_fill) ? span : hist_fill;
                have = 1'b0;
                while (k > 0)
                begin
                    k--;
                    idx = (hist_slot + HIST_DEPTH - (k + 1)) % HIST_DEPTH;
                    if (!have || displaces(hist_mem[idx], held_value))
                    begin
                        held_value = hist_mem[idx];
                        held_bars  = k;
                        have       = 1'b1;
                    end
                end
            end
            else if (displaces(x, held_value))
            begin
                held_value = x;
                held_bars  = 0;
            end
        end
        res.value = held_value;
        res.age   = held_bars[AGE_W-1:0];
        expected_extrema.push_back(res);
    endtask

    // request driver: predicts on acceptance, then offers the next queued sample
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_extremum(sample, series_start);
            // the slot is free when nothing is offered or the offer was just taken
            if (!in_valid || in_ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    sample       <= pending_samples[0].value;
                    series_start <= pending_samples[0].start;
                    in_valid     <= 1'b1;
                    void'(pending_samples.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks against the oldest prediction, drives out_ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (expected_extrema.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: result with no request outstanding: expected none, got %0d / %0d",
                             $time, extreme_value, bars_since);
                end
                else
                begin
                    oldest_extremum = expected_extrema.pop_front();
                    if (extreme_value !== oldest_extremum.value)
                    begin
                        n_errors++;
                        $display("%0t: extreme_value mismatch: expected %0d, got %0d",
                                 $time, oldest_extremum.value, extreme_value);
                    end
                    if (bars_since !== oldest_extremum.age)
                    begin
                        n_errors++;
                        $display("%0t: bars_since mismatch: expected %0d, got %0d",
                                 $time, oldest_extremum.age, bars_since);
                    end
                end
            end
            // one long hold-off so the block backs up and stalls its input
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_ready <= 1'b0;
            end
            else if (!rx_hold_done && n_results >= RX_HOLD_AT)
            begin
                rx_hold_done = 1'b1;
                rx_hold_left = RX_HOLD_LEN;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] value, input logic start);
        sample_req_t r;
        r.value = value;
        r.start = start;
        pending_samples.push_back(r);
    endtask

    // register write, only called with the block idle
    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[WLEN_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WINDOW_LENGTH)
            win_len = val[WLEN_W-1:0];
        else
            track_min = val[0];
        @(negedge clk);
    endtask

    // sender pause until every request has come back as a result
    task automatic wait_drained;
        while (pending_samples.size() != 0 || in_valid || expected_extrema.size() != 0)
            @(negedge clk);
    endtask

    // price-like stream: drifting walk with repeats for ties, rare wild values
    task automatic queue_random(input int count, input int start_pct, input int drift);
        int                         i;
        int unsigned                r;
        logic signed [SAMPLE_W-1:0] v;
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 3)
                v = r[0] ? 32'sh7FFFFFFF : 32'sh80000000;
            else if (r < 10)
                v = $urandom;
            else if (r < 25)
                v = price_walk;
            else
            begin
                price_walk = price_walk + $signed($urandom_range(40)) - 20 + drift;
                v = price_walk;
            end
            push_sample(v, $urandom_range(99) < start_pct);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 12;
        recv_idle_pct = 76;

        // directed: reset settings, window 20 of maximum
        // first request has no series_start but still opens a series
        push_sample(-32'sd5, 1'b0);
        push_sample(32'sh80000000, 1'b0);
        push_sample(32'sh7FFFFFFF, 1'b0);
        push_sample(32'sh7FFFFFFF, 1'b0);   // tie goes to the newer one
        push_sample(32'sd0, 1'b0);
        push_sample(-32'sd1, 1'b0);
        push_sample(32'sh80000000, 1'b1);   // new series
        push_sample(32'sd1, 1'b0);
        push_sample(32'sd1, 1'b0);
        wait_drained();

        // settings changed mid-series: window 3 of minimum, then expiry
        set_register(REG_WINDOW_LENGTH, 3);
        set_register(REG_FIND_MINIMUM, 1);
        push_sample(32'sd7, 1'b0);
        push_sample(32'sd9, 1'b0);
        push_sample(32'sd10, 1'b0);
        push_sample(32'sd11, 1'b0);
        push_sample(32'sd12, 1'b0);
        push_sample(32'sh80000000, 1'b0);
        push_sample(32'sh7FFFFFFF, 1'b0);
        push_sample(32'sh7FFFFFFF, 1'b0);
        push_sample(32'sh7FFFFFFF, 1'b0);
        push_sample(32'sd5, 1'b1);
        push_sample(32'sd5, 1'b0);
        wait_drained();

        // shortest window: every request rescans a single entry
        set_register(REG_WINDOW_LENGTH, 1);
        push_sample(32'sd3, 1'b0);
        push_sample(32'sd2, 1'b0);
        push_sample(32'sd4, 1'b0);
        wait_drained();

        // random, sender idles lightly, receiver heavily
        send_idle_pct = 12;
        recv_idle_pct = 76;
        set_register(REG_WINDOW_LENGTH, 0);
        set_register(REG_FIND_MINIMUM, 0);
        queue_random(50, 4, -2);
        wait_drained();
        set_register(REG_WINDOW_LENGTH, 2);
        set_register(REG_FIND_MINIMUM, 1);
        queue_random(50, 4, 2);
        wait_drained();
        set_register(REG_WINDOW_LENGTH, 20);
        set_register(REG_FIND_MINIMUM, 0);
        queue_random(25, 4, -3);
        wait_drained();                      // pause with settings unchanged
        queue_random(25, 4, -3);
        wait_drained();

        // random, the other way round
        send_idle_pct = 76;
        recv_idle_pct = 12;
        set_register(REG_WINDOW_LENGTH, 7);
        set_register(REG_FIND_MINIMUM, 1);
        queue_random(50, 4, 3);
        wait_drained();
        set_register(REG_WINDOW_LENGTH, 64);
        set_register(REG_FIND_MINIMUM, 0);
        queue_random(50, 3, -1);
        wait_drained();
        set_register(REG_WINDOW_LENGTH, $urandom_range(40, 1));
        set_register(REG_FIND_MINIMUM, $urandom_range(1));
        queue_random(50, 5, 0);
        wait_drained();

        // no idling: window of 40 on a fresh series, long enough to expire
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_register(REG_WINDOW_LENGTH, 40);
        set_register(REG_FIND_MINIMUM, 0);
        push_sample(price_walk, 1'b1);
        queue_random(59, 0, -2);
        wait_drained();
        // oversized window mid-series acts as full depth
        set_register(REG_WINDOW_LENGTH, 2047);
        set_register(REG_FIND_MINIMUM, 1);
        queue_random(20, 0, 2);
        wait_drained();
        // whole-series mode mid-series
        set_register(REG_WINDOW_LENGTH, 0);
        set_register(REG_FIND_MINIMUM, 0);
        queue_random(20, 0, 1);
        wait_drained();
        set_register(REG_WINDOW_LENGTH, 1);
        set_register(REG_FIND_MINIMUM, 1);
        queue_random(30, 5, 0);
        wait_drained();

        // catch any stray result after the last one
        repeat (50) @(posedge clk);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rewa_pkg.sv
rtl/rewa_ram.sv
rtl/rewa_ctrl.sv
rtl/rewa_dp.sv
rtl/rolling_extremum_with_age_core.sv
tb/sv/rolling_extremum_with_age_core_tb.sv
